/* rtl/core/hlg_pkg.sv */
// ----------------------------------------------------------------------------
// hlg_pkg
// Shared types and constants for the Huber loss and gradient core.
// ----------------------------------------------------------------------------
package hlg_pkg;

  // Fixed field widths
  localparam int DATA_W    = 16;   // Q8.8 samples and gradient
  localparam int DELTA_W   = 15;   // unsigned Q7.8 threshold
  localparam int SCALE_W   = 17;   // unsigned Q1.16 reduction factor
  localparam int ABS_W     = 16;   // |prediction - target|
  localparam int LOSS_W    = 50;   // Q.16 loss, also the sum width
  localparam int FRAC_SUM  = 17;   // fractional bits of the running sum
  localparam int ELEM_W    = 32;   // per-element loss product
  localparam int GMAG_W    = 32;   // gradient magnitude product
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;

  // Reset values
  localparam logic [DELTA_W-1:0] DELTA_RST = 15'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 17'd65536;

  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

  // Classified item handed from front to back
  typedef struct packed {
    logic [DELTA_W-1:0] m;     // min(|diff|, delta)
    logic [ABS_W-1:0]   absd;  // |diff|
    logic               neg;   // diff < 0
    logic               last;  // end of batch
  } hlg_item_t;

endpackage

/* rtl/core/hlg_front.sv */
// ----------------------------------------------------------------------------
// hlg_front
// Accepts input transactions, forms |diff| and its sign, and picks the
// quadratic or linear Huber branch by clamping |diff| to delta.
// ----------------------------------------------------------------------------
module hlg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hlg_pkg::DATA_W-1:0]  pred,
  input  logic [hlg_pkg::DATA_W-1:0]  tgt,
  input  logic                        last,
  input  logic [hlg_pkg::DELTA_W-1:0] delta,
  output logic                        push,
  input  logic                        q_full,
  output hlg_pkg::hlg_item_t          item
);
  import hlg_pkg::*;

  logic              valid_r, valid_nxt;
  hlg_item_t         item_r, item_nxt;
  logic signed [DATA_W:0] diff;
  logic [DATA_W:0]   diff_mag;
  logic [ABS_W-1:0]  absd;

  // Difference and magnitude (magnitude never exceeds 65535)
  always_comb begin
    diff     = DATA_W'(0) + ($signed({pred[DATA_W-1], pred}) -
                             $signed({tgt[DATA_W-1], tgt}));
    diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
    absd     = diff_mag[ABS_W-1:0];
  end

  // Branch select: m = |diff| in the quadratic branch, delta otherwise
  always_comb begin
    item_nxt.absd = absd;
    item_nxt.neg  = diff[DATA_W];
    item_nxt.last = last;
    if (absd <= {1'b0, delta}) begin
      item_nxt.m = absd[DELTA_W-1:0];
    end else begin
      item_nxt.m = delta;
    end
  end

  assign push      = valid_r && !q_full;
  assign in_tready = !valid_r || !q_full;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* rtl/core/hlg_queue.sv */
// ----------------------------------------------------------------------------
// hlg_queue
// Short FIFO of classified items between the front and back halves.
// ----------------------------------------------------------------------------
module hlg_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hlg_pkg::hlg_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output hlg_pkg::hlg_item_t pop_item
);
  import hlg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hlg_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/hlg_back.sv */
// ----------------------------------------------------------------------------
// hlg_back
// Four-stage back end: products, accumulate and gradient rounding, batch
// loss partial products, and final loss rounding into the output register.
// All stages advance together whenever the output register can move.
// ----------------------------------------------------------------------------
module hlg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hlg_pkg::SCALE_W-1:0] scale,
  input  logic                        q_empty,
  output logic                        pop,
  input  hlg_pkg::hlg_item_t          item,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hlg_pkg::DATA_W-1:0]  grad,
  output logic [hlg_pkg::LOSS_W-1:0]  loss,
  output logic                        is_last
);
  import hlg_pkg::*;

  localparam int LOP_W = FRAC_SUM + SCALE_W;  // 34
  localparam int RND_W = GMAG_W + 1;

  logic en;

  // Stage 1: products
  logic              s1_valid_r;
  logic [ELEM_W-1:0] s1_elem_r, s1_elem_nxt;
  logic [GMAG_W-1:0] s1_gmag_r, s1_gmag_nxt;
  logic              s1_neg_r, s1_last_r;
  logic [ABS_W:0]    lin_term;

  // Stage 2: accumulate, gradient
  logic              s2_valid_r, s2_last_r;
  logic [DATA_W-1:0] s2_grad_r, s2_grad_nxt;
  logic [LOSS_W-1:0] s2_snap_r, sum_r, sum_nxt, sum_sat;
  logic [LOSS_W:0]   sum_add;
  logic [RND_W-1:0]  g_rnd;
  logic [SCALE_W-1:0] g_mag;

  // Stage 3: loss partial products
  logic              s3_valid_r, s3_last_r;
  logic [DATA_W-1:0] s3_grad_r;
  logic [LOSS_W-1:0] s3_hip_r, s3_hip_nxt;
  logic [LOP_W-1:0]  s3_lop_r, s3_lop_nxt;

  // Stage 4: output register
  logic              out_valid_r, out_last_r;
  logic [DATA_W-1:0] out_grad_r;
  logic [LOSS_W-1:0] out_loss_r, loss_nxt;
  logic [LOSS_W:0]   loss_add;
  logic [LOP_W:0]    lo_rnd;

  assign en  = !out_valid_r || out_tready;
  assign pop = en && !q_empty;

  // Element loss m*(2|d| - m) covers both branches; gradient |m|*scale
  always_comb begin
    lin_term    = {item.absd, 1'b0} - (ABS_W+1)'(item.m);
    s1_elem_nxt = ELEM_W'(item.m * lin_term);
    s1_gmag_nxt = GMAG_W'(item.m * scale);
  end

  // Saturating accumulate; the last item snapshots and clears the sum
  always_comb begin
    sum_add = {1'b0, sum_r} + (LOSS_W+1)'(s1_elem_r);
    sum_sat = sum_add[LOSS_W] ? LOSS_MAX : sum_add[LOSS_W-1:0];
    sum_nxt = s1_last_r ? '0 : sum_sat;
  end

  // Gradient: round to Q8.8 (ties away from zero), then saturate
  always_comb begin
    g_rnd = {1'b0, s1_gmag_r} + RND_W'(32'h8000);
    g_mag = g_rnd[RND_W-1 -: SCALE_W];
    if (!s1_neg_r) begin
      s2_grad_nxt = (g_mag > SCALE_W'(32'h7FFF)) ? DATA_W'(16'h7FFF) : g_mag[DATA_W-1:0];
    end else begin
      s2_grad_nxt = (g_mag > SCALE_W'(32'h8000)) ? DATA_W'(16'h8000)
                                                 : DATA_W'(-g_mag);
    end
  end

  // Loss partial products over the high and low parts of the sum
  always_comb begin
    s3_hip_nxt = LOSS_W'(s2_snap_r[LOSS_W-1:FRAC_SUM] * scale);
    s3_lop_nxt = LOP_W'(s2_snap_r[FRAC_SUM-1:0] * scale);
  end

  // Final loss: round the low part to Q.16 (ties up), add, saturate
  always_comb begin
    lo_rnd   = {1'b0, s3_lop_r} + (LOP_W+1)'(32'h10000);
    loss_add = {1'b0, s3_hip_r} + (LOSS_W+1)'(lo_rnd[LOP_W:FRAC_SUM]);
    if (!s3_last_r) begin
      loss_nxt = '0;
    end else if (loss_add[LOSS_W]) begin
      loss_nxt = LOSS_MAX;
    end else begin
      loss_nxt = loss_add[LOSS_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else if (en) begin
      s1_valid_r  <= !q_empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
      if (s1_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_elem_r  <= s1_elem_nxt;
      s1_gmag_r  <= s1_gmag_nxt;
      s1_neg_r   <= item.neg;
      s1_last_r  <= item.last;
      s2_grad_r  <= s2_grad_nxt;
      s2_last_r  <= s1_last_r;
      s2_snap_r  <= sum_sat;
      s3_grad_r  <= s2_grad_r;
      s3_last_r  <= s2_last_r;
      s3_hip_r   <= s3_hip_nxt;
      s3_lop_r   <= s3_lop_nxt;
      out_grad_r <= s3_grad_r;
      out_last_r <= s3_last_r;
      out_loss_r <= loss_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign grad       = out_grad_r;
  assign loss       = out_loss_r;
  assign is_last    = out_last_r;

endmodule

/* rtl/core/huber_loss_and_gradient_core.sv */
// Path: with no stall on either side, a result passes the front register,
// the queue and the four back-end stages before it is offered.
// Throughput: one item per cycle while neither side stalls; the loss sum is
// one saturating add that closes on itself in back-end stage two.
// Reset: synchronous, active low; clears the loss sum, the queue and all
// valid flags, and loads delta = 1.0 and scale = 1.0.
// ----------------------------------------------------------------------------
// huber_loss_and_gradient_core
// Streaming Huber (smooth L1) loss and gradient over Q8.8 pairs, with a
// batch loss on the transaction marked last.
// ----------------------------------------------------------------------------
module huber_loss_and_gradient_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // [15:0] prediction, [31:16] target
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hlg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  // [15:0] gradient, [65:16] loss, [71:66] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hlg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hlg_pkg::SCALE_W-1:0]     cfg_data
);
  import hlg_pkg::*;

  logic [DELTA_W-1:0] delta_r;
  logic [SCALE_W-1:0] scale_r;
  hlg_item_t          f_item, q_item;
  logic               f_push, q_full, q_empty, b_pop;
  logic [DATA_W-1:0]  b_grad;
  logic [LOSS_W-1:0]  b_loss;

  // Configuration registers; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELTA: delta_r <= cfg_data[DELTA_W-1:0];
        CFG_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hlg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pred      (in_tdata[DATA_W-1:0]),
    .tgt       (in_tdata[2*DATA_W-1:DATA_W]),
    .last      (in_tlast),
    .delta     (delta_r),
    .push      (f_push),
    .q_full    (q_full),
    .item      (f_item)
  );

  hlg_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (b_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  hlg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .scale      (scale_r),
    .q_empty    (q_empty),
    .pop        (b_pop),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .grad       (b_grad),
    .loss       (b_loss),
    .is_last    (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - LOSS_W - DATA_W)'(0), b_loss, b_grad};

endmodule

/* rtl/core/hlg_checker.sv */
// ----------------------------------------------------------------------------
// hlg_checker
// Port-level checks on the Huber core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hlg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hlg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import hlg_pkg::*;

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Loss is only reported on the batch-closing result
  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[LOSS_W+DATA_W-1:DATA_W] == '0)
    else $error("loss nonzero outside batch end");

  // Pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:LOSS_W+DATA_W] == '0)
    else $error("result pad bits set");

  // Reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind huber_loss_and_gradient_core hlg_checker u_hlg_checker (.*);

/* bench/huber_loss_and_gradient_core_tb.sv */
// ----------------------------------------------------------------------------
// huber_loss_and_gradient_core_tb
// Self-checking bench for the streaming Huber loss and gradient core. A
// clocked driver feeds prediction/target pairs from a queue, a clocked
// monitor compares every result transaction (gradient, batch loss, last
// flag) against an in-bench fixed-point model of the core. Both sides idle
// in random bursts. The run covers threshold edges, rounding ties, scale
// and delta extremes, ignored register writes and a full-scale batch.
// ----------------------------------------------------------------------------
module huber_loss_and_gradient_core_tb;
  import hlg_pkg::*;

  localparam int      CYCLE_LIMIT  = 2_000_000;
  localparam int      DRAIN_CYCLES = 32;
  localparam int      GRAD_SHIFT   = 16;      // 2^-24 units down to Q8.8
  localparam int      FULL_ITEMS   = 16;      // full-scale terms in the closing batch
  localparam longint  GRAD_MAX     = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint  GRAD_MIN     = -GRAD_MAX - 1;

  // unused register slots; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] prediction;
    logic [DATA_W-1:0] target;
    logic              last;
  } huber_pair_t;

  typedef struct packed {
    logic [DATA_W-1:0] gradient;
    logic [LOSS_W-1:0] loss;
    logic              is_last;
  } grad_loss_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [SCALE_W-1:0]   data;
  } reg_write_t;

  // DUT connections; the ones the bench drives are known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SCALE_W-1:0]     cfg_data = '0;

  // model state: registers and running sum in 2^-17 units
  logic [DELTA_W-1:0] delta_q = DELTA_RST;
  logic [SCALE_W-1:0] scale_q = SCALE_RST;
  logic [LOSS_W-1:0]  batch_sum = '0;

  huber_pair_t pair_queue[$];
  grad_loss_t  grad_loss_expected[$];
  reg_write_t  reg_writes[$];

  int          items_queued = 0;
  int          items_accepted = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;
  huber_pair_t next_pair;
  grad_loss_t  got_result;
  grad_loss_t  want_result;

  huber_loss_and_gradient_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] prediction, [31:16] target
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] gradient, [65:16] loss, [71:66] zero
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Huber step: accumulate element loss, form gradient, reduce on last
  task automatic predict_huber_step(input logic [DATA_W-1:0] pred,
                                    input logic [DATA_W-1:0] targ,
                                    input logic last);
    longint      diff;
    longint      grad;
    logic        neg;
    logic [63:0] d64;
    logic [63:0] s64;
    logic [63:0] absd;
    logic [63:0] elem;
    logic [63:0] gmag;
    logic [63:0] acc;
    logic [63:0] reduced;
    grad_loss_t  res;
    d64 = 64'(delta_q);
    s64 = 64'(scale_q);
    diff = longint'($signed(pred)) - longint'($signed(targ));
    neg = diff < 0;
    absd = neg ? -diff : diff;
    if (absd <= d64) begin
      elem = absd * absd;
      gmag = absd * s64;
    end else begin
      elem = 2 * d64 * absd - d64 * d64;
      gmag = d64 * s64;
      neg = !(diff > 0);
    end
    // saturating running sum
    acc = 64'(batch_sum) + elem;
    if (acc > 64'(LOSS_MAX)) acc = 64'(LOSS_MAX);
    reduced = '0;
    if (last) begin
      // split so the product stays inside 64 bits; round half up to Q.16
      reduced = (acc >> FRAC_SUM) * s64
              + (((acc & ((64'd1 << FRAC_SUM) - 1)) * s64 + (64'd1 << (FRAC_SUM - 1)))
                 >> FRAC_SUM);
      if (reduced > 64'(LOSS_MAX)) reduced = 64'(LOSS_MAX);
      acc = '0;
    end
    batch_sum = acc[LOSS_W-1:0];
    // round magnitude half away from zero, then clamp
    grad = longint'((gmag + (64'd1 << (GRAD_SHIFT - 1))) >> GRAD_SHIFT);
    if (neg) grad = -grad;
    if (grad > GRAD_MAX) grad = GRAD_MAX;
    if (grad < GRAD_MIN) grad = GRAD_MIN;
    res.gradient = grad[DATA_W-1:0];
    res.loss     = reduced[LOSS_W-1:0];
    res.is_last  = last;
    grad_loss_expected.push_back(res);
  endtask

  task automatic queue_pair(input int pred, input int targ, input bit last);
    huber_pair_t p;
    p.prediction = pred[DATA_W-1:0];
    p.target     = targ[DATA_W-1:0];
    p.last       = last;
    pair_queue.push_back(p);
    items_queued++;
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data[SCALE_W-1:0];
    reg_writes.push_back(w);
  endtask

  // drive queued register writes back to back; model follows each transaction
  task automatic apply_regs();
    reg_write_t w;
    while (reg_writes.size() > 0) begin
      w = reg_writes.pop_front();
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (w.idx)
        CFG_DELTA: delta_q = w.data[DELTA_W-1:0];
        CFG_SCALE: scale_q = w.data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // all queued pairs accepted and all their results back
  task automatic wait_drained();
    do @(posedge clk);
    while (items_accepted != items_queued || grad_loss_expected.size() != 0);
  endtask

  // Input driver: predicts on each accepted transaction, refills when free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_huber_step(in_tdata[DATA_W-1:0], in_tdata[2*DATA_W-1:DATA_W], in_tlast);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 16);
          in_tvalid <= 1'b0;
        end else if (pair_queue.size() > 0) begin
          next_pair = pair_queue.pop_front();
          in_tdata  <= {next_pair.target, next_pair.prediction};
          in_tlast  <= next_pair.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_result.gradient = out_tdata[DATA_W-1:0];
        got_result.loss     = out_tdata[DATA_W+LOSS_W-1:DATA_W];
        got_result.is_last  = out_tlast;
        if (grad_loss_expected.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: grad %0d loss %0d last %b",
                     $signed(got_result.gradient), got_result.loss, got_result.is_last);
        end else begin
          want_result = grad_loss_expected.pop_front();
          if (got_result !== want_result) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: grad exp %0d got %0d, loss exp %0d got %0d, last exp %b got %b",
                       $signed(want_result.gradient), $signed(got_result.gradient),
                       want_result.loss, got_result.loss,
                       want_result.is_last, got_result.is_last);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus and end of test
  initial begin
    int mag;
    int targ;
    int pred;
    int sel;
    int ext[5];
    ext = '{-32768, 32767, 0, -1, 1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: delta 1.0, scale 1.0
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    queue_pair(0, 0, 0);             // zero difference
    queue_pair(256, 0, 0);           // |diff| equal to delta, quadratic
    queue_pair(257, 0, 0);           // just over delta, linear, positive
    queue_pair(0, 257, 0);           // linear, negative
    queue_pair(-256, 0, 0);          // -delta, still quadratic
    queue_pair(32767, -32768, 0);    // largest positive difference
    queue_pair(-32768, 32767, 1);    // largest negative difference, batch end
    queue_pair(-32768, -32768, 1);   // one-item batch of zero difference
    wait_drained();

    // widest delta (upper data bits dropped), half scale, spare slots ignored
    queue_reg(CFG_DELTA, 'h1FFFF);
    queue_reg(CFG_SCALE, 32768);
    queue_reg(CFG_SPARE_2, 'h0AAAA);
    queue_reg(CFG_SPARE_3, 'h15555);
    apply_regs();
    queue_pair(1, 0, 0);             // gradient tie, rounds away from zero
    queue_pair(0, 1, 0);             // negative tie
    queue_pair(3, 0, 0);
    queue_pair(32767, -32768, 0);
    queue_pair(-32768, 32767, 0);
    queue_pair(-1, -1, 1);
    wait_drained();

    // delta zero: every nonzero difference is linear with zero weight
    queue_reg(CFG_DELTA, 0);
    queue_reg(CFG_SCALE, 1);
    apply_regs();
    queue_pair(5, 3, 0);
    queue_pair(0, 0, 0);
    queue_pair(-7, 2, 1);
    wait_drained();

    queue_reg(CFG_DELTA, 100);
    queue_reg(CFG_SCALE, 0);
    apply_regs();
    queue_pair(50, 0, 0);
    queue_pair(-300, 0, 1);
    wait_drained();

    // random chunks, each under its own settings and idling mix
    for (int chunk = 0; chunk < 6; chunk++) begin
      case ($urandom_range(0, 5))
        0: queue_reg(CFG_DELTA, 0);
        1: queue_reg(CFG_DELTA, 32767);
        2: queue_reg(CFG_DELTA, $urandom_range(0, 32767));
        3: queue_reg(CFG_DELTA, $urandom_range(1, 512));
        4: queue_reg(CFG_DELTA, 256);
        default: queue_reg(CFG_DELTA, $urandom_range(0, 'h1FFFF));
      endcase
      case ($urandom_range(0, 5))
        0: queue_reg(CFG_SCALE, 65536);
        1: queue_reg(CFG_SCALE, 0);
        2: queue_reg(CFG_SCALE, 65536 / $urandom_range(1, 100));  // mean over a batch
        3: queue_reg(CFG_SCALE, $urandom_range(0, 65536));
        4: queue_reg(CFG_SCALE, 1);
        default: queue_reg(CFG_SCALE, 32768);
      endcase
      if ($urandom_range(0, 3) == 0)
        queue_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom_range(0, 'h1FFFF));
      apply_regs();
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 100; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          pred = $urandom_range(0, 65535);
          targ = $urandom_range(0, 65535);
        end else if (sel < 9) begin
          // differences clustered around the threshold
          targ = $urandom_range(0, 65535);
          if ($urandom_range(0, 2) == 0)
            mag = int'(delta_q) + $urandom_range(0, 4) - 2;
          else
            mag = $urandom_range(0, int'(delta_q) + 1);
          if (mag < 0) mag = 0;
          pred = $urandom_range(0, 1) ? targ + mag : targ - mag;
        end else begin
          pred = ext[$urandom_range(0, 4)];
          targ = ext[$urandom_range(0, 4)];
        end
        queue_pair(pred, targ, (i == 99) || ($urandom_range(0, 9) == 0));
      end
      wait_drained();
    end

    // closing batch of full-scale terms with scale above 1.0, so every
    // gradient clips; no idling from here on
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    queue_reg(CFG_DELTA, 32767);
    queue_reg(CFG_SCALE, 'h1FFFF);
    apply_regs();
    for (int i = 0; i < FULL_ITEMS; i++) begin
      if ($urandom_range(0, 1))
        queue_pair(32767, -32768, i == FULL_ITEMS - 1);
      else
        queue_pair(-32768, 32767, i == FULL_ITEMS - 1);
    end
    // sum must start over from zero after that batch
    queue_pair(3, 1, 0);
    queue_pair(-2, 2, 1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/hlg_pkg.sv
rtl/core/hlg_front.sv
rtl/core/hlg_queue.sv
rtl/core/hlg_back.sv
rtl/core/huber_loss_and_gradient_core.sv
rtl/core/hlg_checker.sv
bench/huber_loss_and_gradient_core_tb.sv
